FILE: rtl/vdft_pkg.sv
package vdft_pkg;

  localparam int FRAME_COUNT = 1024;
  localparam int FRAME_WORDS = 16;

  localparam int FA_W  = $clog2(FRAME_COUNT);
  localparam int CNT_W = FA_W + 1;
  localparam int WX_W  = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam int SA_W  = $clog2(FRAME_COUNT * FRAME_WORDS);
  localparam int VER_W = 32;
  localparam int WORD_W = 64;
  localparam int NUM_W = 10;

  typedef enum logic [1:0] {
    REQ_COMMIT  = 2'd0,
    REQ_TAKE    = 2'd1,
    REQ_CONFIRM = 2'd2,
    REQ_ROLL    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NONE  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [15:0]       frame_id;
    logic [3:0]        word_index;
    logic [WORD_W-1:0] data_word;
    logic [VER_W-1:0]  version;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NUM_W-1:0]  frame_number;
    logic [VER_W-1:0]  frame_ver;
    logic [WORD_W-1:0] frame_word;
    logic              last;
  } out_t;

  typedef struct packed {
    logic latch;
    logic clr;
    logic cmt_rd;
    logic cmt_wr;
    logic conf_wr;
    logic roll_rd;
    logic roll_end;
    logic scan_rd;
    logic take_hit;
    logic word_rd;
    logic word_out;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       cnt_last;
    logic       scan_done;
    logic       hit;
    logic       word_last;
    logic       out_free;
    logic       out_busy;
  } sts_t;

  function automatic logic [SA_W-1:0] store_addr(logic [FA_W-1:0] f, logic [3:0] w);
    return SA_W'(f) * SA_W'(FRAME_WORDS) + SA_W'(w);
  endfunction

endpackage

FILE: rtl/vdft_ctrl.sv
module vdft_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  vdft_pkg::sts_t sts,
  output vdft_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_CMT      = 11'b00000000100,
    S_CMT_WR   = 11'b00000001000,
    S_CONF     = 11'b00000010000,
    S_ROLL     = 11'b00000100000,
    S_ROLL_END = 11'b00001000000,
    S_SCAN_RD  = 11'b00010000000,
    S_SCAN_CMP = 11'b00100000000,
    S_WORD_RD  = 11'b01000000000,
    S_WORD_LD  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE) || sts.out_busy;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !sts.out_busy) begin
          cmd.latch = 1'b1;
          unique case (sts.req)
            vdft_pkg::REQ_COMMIT:  state_nxt = S_CMT;
            vdft_pkg::REQ_TAKE:    state_nxt = S_SCAN_RD;
            vdft_pkg::REQ_CONFIRM: state_nxt = S_CONF;
            vdft_pkg::REQ_ROLL:    state_nxt = S_ROLL;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_CMT: begin
        cmd.cmt_rd = 1'b1;
        state_nxt = S_CMT_WR;
      end
      S_CMT_WR: begin
        cmd.cmt_wr = 1'b1;
        cmd.resp = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CONF: begin
        cmd.conf_wr = 1'b1;
        cmd.resp = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ROLL: begin
        cmd.roll_rd = 1'b1;
        if (sts.cnt_last) state_nxt = S_ROLL_END;
      end
      S_ROLL_END: begin
        cmd.roll_end = 1'b1;
        cmd.resp = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        priority if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt = S_WORD_RD;
        end else if (sts.scan_done) begin
          cmd.resp = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_WORD_RD: begin
        cmd.word_rd = 1'b1;
        state_nxt = S_WORD_LD;
      end
      S_WORD_LD: begin
        if (sts.out_free) begin
          cmd.word_out = 1'b1;
          state_nxt = sts.word_last ? S_IDLE : S_WORD_RD;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

FILE: rtl/vdft_dp.sv
module vdft_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  vdft_pkg::in_t  in_data,
  input  vdft_pkg::cmd_t cmd,
  output vdft_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_stall,
  output vdft_pkg::out_t out_data
);

  localparam int FA_W  = vdft_pkg::FA_W;
  localparam int CNT_W = vdft_pkg::CNT_W;
  localparam int WX_W  = vdft_pkg::WX_W;
  localparam int VER_W = vdft_pkg::VER_W;
  localparam int WORD_W = vdft_pkg::WORD_W;
  localparam int FC = vdft_pkg::FRAME_COUNT;
  localparam int FW = vdft_pkg::FRAME_WORDS;

  logic [WORD_W-1:0] store_mem [FC*FW];
  logic [VER_W-1:0]  wv_mem    [FC];
  logic [VER_W-1:0]  seen_mem  [FC];
  logic [VER_W-1:0]  sync_mem  [FC];

  vdft_pkg::in_t     req_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [FA_W-1:0]   scan_r;
  logic [FA_W-1:0]   cand_r;
  logic [WX_W-1:0]   wcnt_r;
  logic [VER_W-1:0]  ver_r;
  logic              pend_r;
  logic [FA_W-1:0]   pend_addr_r;
  logic [WORD_W-1:0] store_q;
  logic [VER_W-1:0]  wv_q, seen_q, sync_q;
  vdft_pkg::out_t    out_r;
  vdft_pkg::out_t    out_nxt;
  logic              out_v_r;

  logic [FA_W-1:0]   frame;
  logic              in_range, widx_ok;
  logic [VER_W-1:0]  v1, v2;
  logic [FA_W-1:0]   cnt_idx;
  logic [FA_W-1:0]   scan_nxt;
  logic [1:0]        resp_st;

  assign frame    = req_r.frame_id[FA_W-1:0];
  assign in_range = {1'b0, req_r.frame_id} < 17'(FC);
  assign widx_ok  = {1'b0, req_r.word_index} < 5'(FW);
  assign cnt_idx  = cnt_r[FA_W-1:0];
  assign scan_nxt = (scan_r == FA_W'(FC - 1)) ? '0 : scan_r + 1'b1;

  always_comb begin
    v1 = wv_q;
    if (req_r.word_index == 4'd0) v1 = wv_q[0] ? wv_q + 2'd2 : wv_q + 1'b1;
    v2 = v1;
    if (req_r.word_index == 4'(FW - 1) && v1[0]) v2 = v1 + 1'b1;
  end

  always_comb begin
    unique case (req_r.req_type)
      vdft_pkg::REQ_COMMIT, vdft_pkg::REQ_CONFIRM:
        resp_st = in_range ? vdft_pkg::ST_OK : vdft_pkg::ST_RANGE;
      vdft_pkg::REQ_TAKE: resp_st = vdft_pkg::ST_NONE;
      default:            resp_st = vdft_pkg::ST_OK;
    endcase
  end

  assign sts.req       = in_data.req_type;
  assign sts.cnt_last  = cnt_idx == FA_W'(FC - 1);
  assign sts.scan_done = cnt_r == CNT_W'(FC);
  assign sts.hit       = !wv_q[0] && (wv_q != seen_q);
  assign sts.word_last = wcnt_r == WX_W'(FW - 1);
  assign sts.out_free  = !out_v_r || !out_stall;
  assign sts.out_busy  = out_v_r;

  always_ff @(posedge clk) begin
    if (cmd.cmt_rd && in_range && widx_ok)
      store_mem[vdft_pkg::store_addr(frame, req_r.word_index)] <= req_r.data_word;
    if (cmd.word_rd)
      store_q <= store_mem[vdft_pkg::store_addr(cand_r, 4'(wcnt_r))];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) wv_mem[cnt_idx] <= '0;
    else if (cmd.cmt_wr && in_range && widx_ok) wv_mem[frame] <= v2;
    if (cmd.cmt_rd) wv_q <= wv_mem[frame];
    else if (cmd.scan_rd) wv_q <= wv_mem[scan_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) seen_mem[cnt_idx] <= '0;
    else if (cmd.take_hit) seen_mem[cand_r] <= wv_q;
    else if (pend_r) seen_mem[pend_addr_r] <= sync_q;
    if (cmd.scan_rd) seen_q <= seen_mem[scan_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) sync_mem[cnt_idx] <= '0;
    else if (cmd.conf_wr && in_range) sync_mem[frame] <= req_r.version;
    if (cmd.roll_rd) sync_q <= sync_mem[cnt_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) req_r <= in_data;
    if (cmd.scan_rd) cand_r <= scan_r;
    if (cmd.take_hit) ver_r <= wv_q;
    pend_addr_r <= cnt_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      scan_r <= '0;
      wcnt_r <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.roll_rd;
      priority if (cmd.latch) cnt_r <= '0;
      else if (cmd.clr && sts.cnt_last) cnt_r <= '0;
      else if (cmd.clr || cmd.roll_rd || cmd.scan_rd) cnt_r <= cnt_r + 1'b1;
      if (cmd.scan_rd) scan_r <= scan_nxt;
      else if (cmd.roll_end) scan_r <= '0;
      if (cmd.take_hit) wcnt_r <= '0;
      else if (cmd.word_out) wcnt_r <= wcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (cmd.resp || cmd.word_out) out_v_r <= 1'b1;
    else if (!out_stall) out_v_r <= 1'b0;
  end

  always_comb begin
    out_nxt = '0;
    if (cmd.word_out) begin
      out_nxt.status       = vdft_pkg::ST_OK;
      out_nxt.frame_number = vdft_pkg::NUM_W'(cand_r);
      out_nxt.frame_ver    = ver_r;
      out_nxt.frame_word   = store_q;
      out_nxt.last         = sts.word_last;
    end else begin
      out_nxt.status = resp_st;
      out_nxt.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp || cmd.word_out) out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resp || cmd.word_out) |-> (!out_v_r || !out_stall))
    else $error("result register overwritten");
  a_cmt_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cmt_wr |-> $past(cmd.cmt_rd))
    else $error("version write without read");
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_hit |-> $past(cmd.scan_rd))
    else $error("take hit without scan read");
  a_roll_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.roll_end |-> pend_r)
    else $error("rollback end without pending copy");

endmodule

FILE: rtl/versioned_dirty_frame_tracker.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   vdft_pkg::in_t
// out      output     out_valid / out_stall vdft_pkg::out_t
// After reset a clearing pass zeroes the version tables; no item is taken then.
// Commit: version read, then write. Confirm: sync write. Rollback: one table entry a cycle.
// Take: read, compare per frame checked (version table read port); read, load per frame word.
// A new item is taken once the result register is empty; out_stall holds the result.
module versioned_dirty_frame_tracker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  vdft_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output vdft_pkg::out_t out_data
);

  vdft_pkg::cmd_t cmd;
  vdft_pkg::sts_t sts;

  vdft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vdft_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
